// ===== hw/rtl/ebv_pkg.sv =====
// Shared types, constants and helpers for the exhaust billboard vertex generator.
`timescale 1ns / 1ps
package ebv_pkg;

	localparam int COORD_W     = 32;
	localparam int SCALE_W     = 31;
	localparam int UNIT_W      = 19;
	localparam int QUO_W       = 18;
	localparam int TERM_W      = 66;
	localparam int CNT_W       = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [2:0] LAST_IDX = 3'd7;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [SCALE_W-1:0] scale_t;

	typedef struct packed {
		coord_t ex;
		coord_t ey;
		coord_t ez;
		coord_t cx;
		coord_t cy;
		coord_t cz;
		coord_t ox;
		coord_t oy;
		coord_t oz;
		scale_t len;
		scale_t wid;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_MAG,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DINIT,
		ST_DIV,
		ST_UNIT,
		ST_TERM,
		ST_EMIT
	} state_t;

	// Q16.16 scale-back, rounding half away from zero
	function automatic logic signed [TERM_W-1:0] round_q16(input logic signed [TERM_W-1:0] v);
		logic neg;
		logic [TERM_W-1:0] mag;
		neg = v[TERM_W-1];
		mag = neg ? TERM_W'(-v) : TERM_W'(v);
		mag = (mag + TERM_W'(32768)) >> 16;
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

// ===== hw/rtl/ebv_queue.sv =====
// Input item queue between the accepting front and the compute back end.
`timescale 1ns / 1ps
module ebv_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ebv_pkg::item_t  din,
	input  logic            pop,
	output ebv_pkg::item_t  dout,
	output ebv_pkg::q_stat_t stat
);
	import ebv_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic do_push, do_pop;

	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ebv_core.sv =====
// Back end: axis construction, normalization, term products and vertex emission.
`timescale 1ns / 1ps
module ebv_core #(
	parameter int FLARE_FACTOR = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ebv_pkg::item_t          q_item,
	input  ebv_pkg::q_stat_t        q_stat,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              vertex_index,
	output ebv_pkg::coord_t         vertex_x,
	output ebv_pkg::coord_t         vertex_y,
	output ebv_pkg::coord_t         vertex_z,
	output logic                    degenerate,
	output logic                    last_vertex
);
	import ebv_pkg::*;

	localparam logic signed [TERM_W-1:0] FF_T = TERM_W'(FLARE_FACTOR);
	localparam int SUM_W = TERM_W + 2;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic pass_q;

	logic signed [31:0] e_q [3];
	logic signed [31:0] c_q [3];
	logic signed [31:0] r_q [3];
	logic [SCALE_W-1:0] l_q, w_q;
	logic signed [63:0] prod_q, p1_q;
	logic signed [64:0] wv_q [3];
	logic [63:0] mag_q [3];
	logic neg_q [3];
	logic [61:0] sum_q;
	logic [63:0] root_q;
	logic [31:0] len_q;
	logic [47:0] rem_q [3];
	logic [QUO_W-1:0] quo_q [3];
	logic signed [UNIT_W-1:0] su_q [3];
	logic signed [UNIT_W-1:0] tu_q [3];
	logic signed [TERM_W-1:0] s_q [3];
	logic signed [TERM_W-1:0] fs_q [3];
	logic signed [TERM_W-1:0] ex_q [3];
	logic signed [TERM_W-1:0] t_q [3];
	logic degen_q;

	logic out_valid_q, last_q, degen_out_q;
	logic [2:0] vidx_q;
	coord_t vx_q, vy_q, vz_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [32:0] v_op [3];
	logic [63:0] mx;
	logic mx_zero, mx_done;
	logic [63:0] bitv, tsum;
	logic [3:0] idx;
	logic [2:0] midx;
	logic signed [TERM_W-1:0] rnd;
	logic load;
	coord_t vert [3];
	logic signed [SUM_W-1:0] vsum [3];

	assign idx  = 4'(cnt_q - 1'b1);
	assign midx = idx[2:0];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			v_op[j] = pass_q ? 33'(su_q[j]) : 33'(e_q[j]);
		end
	end

	// largest magnitude and normalization checks
	always_comb begin
		mx = mag_q[0];
		if (mag_q[1] > mx) mx = mag_q[1];
		if (mag_q[2] > mx) mx = mag_q[2];
		mx_zero = (mx == '0);
		mx_done = (mx[63:30] == '0) && mx[29];
	end

	assign bitv = 64'(1) << {cnt_q[4:0], 1'b0};
	assign tsum = root_q + bitv;
	assign load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		rnd = round_q16((idx >= 4'd6) ? TERM_W'(prod_q) * FF_T : TERM_W'(prod_q));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (!q_stat.empty) state_d = ST_MUL;
			ST_MUL:   if (cnt_q == 6'd6) state_d = ST_MAG;
			ST_MAG:   state_d = ST_SHIFT;
			ST_SHIFT: begin
				if (mx_zero) state_d = pass_q ? ST_TERM : ST_MUL;
				else if (mx_done) state_d = ST_SQ;
			end
			ST_SQ:    if (cnt_q == 6'd3) state_d = ST_SQRT;
			ST_SQRT:  if (cnt_q == '0) state_d = ST_DINIT;
			ST_DINIT: state_d = ST_DIV;
			ST_DIV:   if (cnt_q == '0) state_d = ST_UNIT;
			ST_UNIT:  state_d = pass_q ? ST_TERM : ST_MUL;
			ST_TERM:  if (cnt_q == 6'd9) state_d = ST_EMIT;
			ST_EMIT:  if (load && cnt_q[2:0] == LAST_IDX) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs: queue pop and multiplier operands
	always_comb begin
		q_pop = (state_q == ST_IDLE) && !q_stat.empty;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL: begin
				case (cnt_q[2:0])
					3'd0: begin mul_a = 33'(c_q[1]); mul_b = v_op[2]; end
					3'd1: begin mul_a = 33'(c_q[2]); mul_b = v_op[1]; end
					3'd2: begin mul_a = 33'(c_q[2]); mul_b = v_op[0]; end
					3'd3: begin mul_a = 33'(c_q[0]); mul_b = v_op[2]; end
					3'd4: begin mul_a = 33'(c_q[0]); mul_b = v_op[1]; end
					3'd5: begin mul_a = 33'(c_q[1]); mul_b = v_op[0]; end
					default: ;
				endcase
			end
			ST_SQ: begin
				case (cnt_q[1:0])
					2'd0: begin
						mul_a = $signed({3'b0, mag_q[0][29:0]});
						mul_b = $signed({3'b0, mag_q[0][29:0]});
					end
					2'd1: begin
						mul_a = $signed({3'b0, mag_q[1][29:0]});
						mul_b = $signed({3'b0, mag_q[1][29:0]});
					end
					2'd2: begin
						mul_a = $signed({3'b0, mag_q[2][29:0]});
						mul_b = $signed({3'b0, mag_q[2][29:0]});
					end
					default: ;
				endcase
			end
			ST_TERM: begin
				case (cnt_q[3:0])
					4'd0: begin mul_a = 33'(su_q[0]); mul_b = $signed({2'b0, w_q}); end
					4'd1: begin mul_a = 33'(su_q[1]); mul_b = $signed({2'b0, w_q}); end
					4'd2: begin mul_a = 33'(su_q[2]); mul_b = $signed({2'b0, w_q}); end
					4'd3: begin mul_a = 33'(e_q[0]); mul_b = $signed({2'b0, l_q}); end
					4'd4: begin mul_a = 33'(e_q[1]); mul_b = $signed({2'b0, l_q}); end
					4'd5: begin mul_a = 33'(e_q[2]); mul_b = $signed({2'b0, l_q}); end
					4'd6: begin mul_a = 33'(tu_q[0]); mul_b = $signed({2'b0, w_q}); end
					4'd7: begin mul_a = 33'(tu_q[1]); mul_b = $signed({2'b0, w_q}); end
					4'd8: begin mul_a = 33'(tu_q[2]); mul_b = $signed({2'b0, w_q}); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// vertex assembly for the current index
	always_comb begin
		logic signed [SUM_W-1:0] ta, tb;
		for (int j = 0; j < 3; j++) begin
			ta = cnt_q[2] ? SUM_W'(fs_q[j]) : SUM_W'(s_q[j]);
			tb = cnt_q[2] ? SUM_W'(t_q[j]) : SUM_W'(ex_q[j]);
			case (cnt_q[2:0])
				3'd0: vsum[j] = SUM_W'(r_q[j]) + ta;
				3'd1: vsum[j] = SUM_W'(r_q[j]) + ta + tb;
				3'd2: vsum[j] = SUM_W'(r_q[j]) - ta;
				3'd3: vsum[j] = SUM_W'(r_q[j]) - ta + tb;
				3'd4: vsum[j] = SUM_W'(r_q[j]) - ta + tb;
				3'd5: vsum[j] = SUM_W'(r_q[j]) + ta + tb;
				3'd6: vsum[j] = SUM_W'(r_q[j]) - ta - tb;
				default: vsum[j] = SUM_W'(r_q[j]) + ta - tb;
			endcase
			if (vsum[j] > SUM_W'(64'sd2147483647)) begin
				vert[j] = 32'sh7FFFFFFF;
			end else if (vsum[j] < -SUM_W'(64'sd2147483648)) begin
				vert[j] = 32'sh80000000;
			end else begin
				vert[j] = vsum[j][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					pass_q <= 1'b0;
				end
				ST_MUL, ST_SQ, ST_TERM: begin
					if (state_d == ST_EMIT) cnt_q <= '0;
					else if (state_d == state_q) cnt_q <= cnt_q + 1'b1;
					else cnt_q <= 6'd31;
				end
				ST_SHIFT: begin
					if (mx_zero) begin
						cnt_q  <= '0;
						pass_q <= 1'b1;
					end else begin
						cnt_q <= '0;
					end
				end
				ST_SQRT: cnt_q <= cnt_q - 1'b1;
				ST_DINIT: cnt_q <= 6'd17;
				ST_DIV: cnt_q <= cnt_q - 1'b1;
				ST_UNIT: begin
					cnt_q  <= '0;
					pass_q <= 1'b1;
				end
				ST_EMIT: if (load) cnt_q <= cnt_q + 1'b1;
				default: ;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_p);
		case (state_q)
			ST_IDLE: begin
				e_q[0] <= q_item.ex; e_q[1] <= q_item.ey; e_q[2] <= q_item.ez;
				c_q[0] <= q_item.cx; c_q[1] <= q_item.cy; c_q[2] <= q_item.cz;
				r_q[0] <= q_item.ox; r_q[1] <= q_item.oy; r_q[2] <= q_item.oz;
				l_q <= q_item.len;
				w_q <= q_item.wid;
				degen_q <= 1'b0;
			end
			ST_MUL: begin
				if (cnt_q != '0) begin
					case (midx)
						3'd1: wv_q[0] <= 65'(p1_q) - 65'(prod_q);
						3'd3: wv_q[1] <= 65'(p1_q) - 65'(prod_q);
						3'd5: wv_q[2] <= 65'(p1_q) - 65'(prod_q);
						default: p1_q <= prod_q;
					endcase
				end
			end
			ST_MAG: begin
				for (int j = 0; j < 3; j++) begin
					neg_q[j] <= wv_q[j][64];
					mag_q[j] <= wv_q[j][64] ? 64'(-wv_q[j]) : 64'(wv_q[j]);
				end
				sum_q <= '0;
			end
			ST_SHIFT: begin
				for (int j = 0; j < 3; j++) begin
					if (mx[63:38] != '0) mag_q[j] <= mag_q[j] >> 8;
					else if (mx[63:30] != '0) mag_q[j] <= mag_q[j] >> 1;
					else if (mx[29:22] == '0) mag_q[j] <= mag_q[j] << 8;
					else if (!mx[29]) mag_q[j] <= mag_q[j] << 1;
				end
				if (mx_zero) begin
					degen_q <= 1'b1;
					for (int j = 0; j < 3; j++) begin
						if (pass_q) tu_q[j] <= '0;
						else su_q[j] <= '0;
					end
				end
			end
			ST_SQ: begin
				if (cnt_q != '0) sum_q <= sum_q + prod_q[61:0];
				root_q <= '0;
			end
			ST_SQRT: begin
				if ({2'b0, sum_q} >= tsum) begin
					sum_q  <= sum_q - tsum[61:0];
					root_q <= (root_q >> 1) + bitv;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			ST_DINIT: begin
				len_q <= root_q[31:0];
				for (int j = 0; j < 3; j++) begin
					rem_q[j] <= 48'({mag_q[j][29:0], 16'b0}) + 48'(root_q[31:1]);
					quo_q[j] <= '0;
				end
			end
			ST_DIV: begin
				for (int j = 0; j < 3; j++) begin
					if (50'(rem_q[j]) >= (50'(len_q) << cnt_q[4:0])) begin
						rem_q[j] <= 48'(50'(rem_q[j]) - (50'(len_q) << cnt_q[4:0]));
						quo_q[j][cnt_q[4:0]] <= 1'b1;
					end
				end
			end
			ST_UNIT: begin
				for (int j = 0; j < 3; j++) begin
					if (pass_q) tu_q[j] <= neg_q[j] ? -$signed(UNIT_W'(quo_q[j])) :
						$signed(UNIT_W'(quo_q[j]));
					else su_q[j] <= neg_q[j] ? -$signed(UNIT_W'(quo_q[j])) :
						$signed(UNIT_W'(quo_q[j]));
				end
			end
			ST_TERM: begin
				if (cnt_q != '0) begin
					case (idx)
						4'd0: begin s_q[0] <= rnd; fs_q[0] <= TERM_W'(rnd * FF_T); end
						4'd1: begin s_q[1] <= rnd; fs_q[1] <= TERM_W'(rnd * FF_T); end
						4'd2: begin s_q[2] <= rnd; fs_q[2] <= TERM_W'(rnd * FF_T); end
						4'd3: ex_q[0] <= rnd;
						4'd4: ex_q[1] <= rnd;
						4'd5: ex_q[2] <= rnd;
						4'd6: t_q[0] <= rnd;
						4'd7: t_q[1] <= rnd;
						default: t_q[2] <= rnd;
					endcase
				end
			end
			default: ;
		endcase
		if (load) begin
			vidx_q      <= cnt_q[2:0];
			vx_q        <= vert[0];
			vy_q        <= vert[1];
			vz_q        <= vert[2];
			degen_out_q <= degen_q;
			last_q      <= (cnt_q[2:0] == LAST_IDX);
		end
	end

	assign out_valid    = out_valid_q;
	assign vertex_index = vidx_q;
	assign vertex_x     = vx_q;
	assign vertex_y     = vy_q;
	assign vertex_z     = vz_q;
	assign degenerate   = degen_out_q;
	assign last_vertex  = last_q;

endmodule

// ===== hw/rtl/exhaust_billboard_vertex_gen.sv =====
// Top level of the exhaust billboard vertex generator.
// Each item yields eight vertices. Per axis the core runs a normalization shift, the bit-serial
// square root (32 steps) and the divider (18 steps); a zero first cross product skips the
// square root and divider on both axes. The core takes a new item only after the last vertex
// of the one before, and output stalls hold it; the two-entry input queue takes new items
// meanwhile.
// Reset (arst_n, asynchronous, active low) empties the queue and idles the sequencer.
`timescale 1ns / 1ps
module exhaust_billboard_vertex_gen #(
	parameter int FLARE_FACTOR = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ebv_pkg::coord_t       exhaust_dir_x,
	input  ebv_pkg::coord_t       exhaust_dir_y,
	input  ebv_pkg::coord_t       exhaust_dir_z,
	input  ebv_pkg::coord_t       camera_dir_x,
	input  ebv_pkg::coord_t       camera_dir_y,
	input  ebv_pkg::coord_t       camera_dir_z,
	input  ebv_pkg::coord_t       origin_x,
	input  ebv_pkg::coord_t       origin_y,
	input  ebv_pkg::coord_t       origin_z,
	input  ebv_pkg::scale_t       length_scale,
	input  ebv_pkg::scale_t       width_scale,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            vertex_index,
	output ebv_pkg::coord_t       vertex_x,
	output ebv_pkg::coord_t       vertex_y,
	output ebv_pkg::coord_t       vertex_z,
	output logic                  degenerate,
	output logic                  last_vertex
);
	import ebv_pkg::*;

	item_t in_item, q_item;
	q_stat_t q_stat;
	logic q_pop;

	assign in_item = '{ex: exhaust_dir_x, ey: exhaust_dir_y, ez: exhaust_dir_z,
		cx: camera_dir_x, cy: camera_dir_y, cz: camera_dir_z,
		ox: origin_x, oy: origin_y, oz: origin_z,
		len: length_scale, wid: width_scale};
	assign in_ready = !q_stat.full;

	ebv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid && in_ready),
		.din    (in_item),
		.pop    (q_pop),
		.dout   (q_item),
		.stat   (q_stat)
	);

	ebv_core #(
		.FLARE_FACTOR (FLARE_FACTOR)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_item       (q_item),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vertex_index (vertex_index),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.degenerate   (degenerate),
		.last_vertex  (last_vertex)
	);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_vertex |-> vertex_index == LAST_IDX)
		else $error("last flag on wrong vertex");

	a_next_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_vertex |=>
			out_valid && vertex_index == $past(vertex_index) + 3'd1)
		else $error("vertex sequence broken");

	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !q_stat.empty)
		else $error("queue lost a transfer");

endmodule
